// ----- sv/hsv2rgb_pkg.sv -----
// Shared types and constants for the HSV to RGB converter.
package hsv2rgb_pkg;

  localparam int unsigned HueW   = 9;
  localparam int unsigned QW     = 16;
  localparam int unsigned LvlW   = 15;
  localparam int unsigned WtW    = 6;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned FracW  = 14;

  localparam logic [LvlW-1:0] OneQ14   = 15'd16384;
  localparam logic [HueW-1:0] HueWrap  = 9'd360;
  localparam logic [HueW-1:0] Hue60    = 9'd60;
  localparam logic [HueW-1:0] Hue120   = 9'd120;
  localparam logic [HueW-1:0] Hue180   = 9'd180;
  localparam logic [HueW-1:0] Hue240   = 9'd240;
  localparam logic [HueW-1:0] Hue300   = 9'd300;

  // floor(q / 15) == (q * Recip15) >> Recip15Sh for q below 2^18
  localparam int unsigned     Recip15Sh = 22;
  localparam logic [18:0]     Recip15   = 19'd279621;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  function automatic logic [LvlW-1:0] clamp_q14(input logic [QW-1:0] raw);
    logic [LvlW-1:0] res;
    if (raw[QW-1]) begin
      res = '0;
    end else if (raw[QW-2:0] > OneQ14) begin
      res = OneQ14;
    end else begin
      res = raw[LvlW-1:0];
    end
    return res;
  endfunction

  function automatic logic [ChanW-1:0] scale_chan(input logic [LvlW-1:0] lvl);
    logic [LvlW+ChanW-1:0] prod;
    prod = {lvl, {ChanW{1'b0}}} - {{ChanW{1'b0}}, lvl};
    return prod[FracW +: ChanW];
  endfunction

endpackage

// ----- sv/hsv_to_rgb_converter.sv -----
// Five-stage pipelined HSV to RGB pixel converter.
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+----
//  in      | in_valid_i, in_stall_o, hue_deg_i,             | in
//          | saturation_i, brightness_i                     |
//  out     | out_valid_o, out_stall_i, red_o, green_o,      | out
//          | blue_o                                         |
//
// One word per cycle when not stalled; one stage per multiplier
// (value*saturation, chroma*weight, divide by 60 via reciprocal) plus
// a clamp/sector stage and a mix/scale stage that drives the outputs.
// Reset clears the valid bits of every stage. A stall on the output
// holds only the full stages behind it; bubbles keep filling.
module hsv_to_rgb_converter (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [8:0]              hue_deg_i,
  input  logic signed [15:0]      saturation_i,
  input  logic signed [15:0]      brightness_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [7:0]              red_o,
  output logic [7:0]              green_o,
  output logic [7:0]              blue_o
);
  import hsv2rgb_pkg::*;

  logic [4:0] vld_q;
  logic [4:0] en;

  logic [HueW-1:0]      hue;
  logic [HueW-1:0]      rem;
  sector_e              sec;
  logic [WtW-1:0]       wt;

  sector_e              s1_sec_q, s2_sec_q, s3_sec_q, s4_sec_q;
  logic [WtW-1:0]       s1_wt_q, s2_wt_q;
  logic [LvlW-1:0]      s1_sat_q, s1_val_q, s2_val_q;
  logic [LvlW-1:0]      s2_chr_q, s3_chr_q, s4_chr_q;
  logic [LvlW-1:0]      s3_base_q, s4_base_q;
  logic [19:0]          s3_prod_q;
  logic [LvlW-1:0]      s4_sec_lvl_q;
  logic [ChanW-1:0]     red_q, green_q, blue_q;

  logic [2*LvlW-1:0]    chr_prod;
  logic [LvlW+WtW-1:0]  wt_prod;
  logic [36:0]          div_prod;
  logic [LvlW-1:0]      r_c, g_c, b_c;

  assign en[4] = !vld_q[4] || !out_stall_i;
  assign en[3] = !vld_q[3] || en[4];
  assign en[2] = !vld_q[2] || en[3];
  assign en[1] = !vld_q[1] || en[2];
  assign en[0] = !vld_q[0] || en[1];
  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      if (en[1]) vld_q[1] <= vld_q[0];
      if (en[2]) vld_q[2] <= vld_q[1];
      if (en[3]) vld_q[3] <= vld_q[2];
      if (en[4]) vld_q[4] <= vld_q[3];
    end
  end

  always_comb begin
    hue = (hue_deg_i >= HueWrap) ? '0 : hue_deg_i;
    if (hue < Hue60) begin
      sec = SEC_RED_YEL;
      rem = hue;
    end else if (hue < Hue120) begin
      sec = SEC_YEL_GRN;
      rem = hue;
    end else if (hue < Hue180) begin
      sec = SEC_GRN_CYN;
      rem = hue - Hue120;
    end else if (hue < Hue240) begin
      sec = SEC_CYN_BLU;
      rem = hue - Hue120;
    end else if (hue < Hue300) begin
      sec = SEC_BLU_MAG;
      rem = hue - Hue240;
    end else begin
      sec = SEC_MAG_RED;
      rem = hue - Hue240;
    end
    if (rem >= Hue60) begin
      wt = WtW'(Hue120 - rem);
    end else begin
      wt = rem[WtW-1:0];
    end
  end

  assign chr_prod = (2*LvlW)'(s1_val_q) * (2*LvlW)'(s1_sat_q);
  assign wt_prod  = (LvlW+WtW)'(s2_chr_q) * (LvlW+WtW)'(s2_wt_q);
  assign div_prod = 37'({1'b0, s3_prod_q[19:2]}) * 37'(Recip15);

  always_comb begin
    case (s4_sec_q)
      SEC_RED_YEL: begin r_c = s4_chr_q;     g_c = s4_sec_lvl_q; b_c = '0;           end
      SEC_YEL_GRN: begin r_c = s4_sec_lvl_q; g_c = s4_chr_q;     b_c = '0;           end
      SEC_GRN_CYN: begin r_c = '0;           g_c = s4_chr_q;     b_c = s4_sec_lvl_q; end
      SEC_CYN_BLU: begin r_c = '0;           g_c = s4_sec_lvl_q; b_c = s4_chr_q;     end
      SEC_BLU_MAG: begin r_c = s4_sec_lvl_q; g_c = '0;           b_c = s4_chr_q;     end
      default:     begin r_c = s4_chr_q;     g_c = '0;           b_c = s4_sec_lvl_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_sec_q <= sec;
      s1_wt_q  <= wt;
      s1_sat_q <= clamp_q14(saturation_i);
      s1_val_q <= clamp_q14(brightness_i);
    end
    if (en[1]) begin
      s2_sec_q <= s1_sec_q;
      s2_wt_q  <= s1_wt_q;
      s2_val_q <= s1_val_q;
      s2_chr_q <= chr_prod[FracW +: LvlW];
    end
    if (en[2]) begin
      s3_sec_q  <= s2_sec_q;
      s3_chr_q  <= s2_chr_q;
      s3_base_q <= s2_val_q - s2_chr_q;
      s3_prod_q <= wt_prod[19:0];
    end
    if (en[3]) begin
      s4_sec_q     <= s3_sec_q;
      s4_chr_q     <= s3_chr_q;
      s4_base_q    <= s3_base_q;
      s4_sec_lvl_q <= div_prod[Recip15Sh +: LvlW];
    end
    if (en[4]) begin
      red_q   <= scale_chan(r_c + s4_base_q);
      green_q <= scale_chan(g_c + s4_base_q);
      blue_q  <= scale_chan(b_c + s4_base_q);
    end
  end

  assign out_valid_o = vld_q[4];
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the pipelined HSV to RGB pixel converter.
`timescale 1ns / 100ps

module testbench;
  import hsv2rgb_pkg::*;

  localparam int unsigned ChanFull  = 255;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned RandomN   = 1450;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct {
    logic [8:0]  hue;
    logic [15:0] sat;
    logic [15:0] val;
    int unsigned gap;
    bit          drain;
  } pixel_req_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [8:0]         hue_deg_i    = '0;
  logic signed [15:0] saturation_i = '0;
  logic signed [15:0] brightness_i = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [7:0]         red_o;
  logic [7:0]         green_o;
  logic [7:0]         blue_o;

  pixel_req_t  pending_q[$];
  rgb_t        expected_rgb_q[$];
  int unsigned cur_gap    = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned words_in   = 0;
  int unsigned words_out  = 0;
  int unsigned mismatches = 0;
  int unsigned idle_count = 0;
  int unsigned directed_n = 0;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  hsv_to_rgb_converter i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .hue_deg_i    (hue_deg_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned clip_level(input logic [15:0] raw);
    if (raw[15]) return 0;
    if (raw > OneQ14) return OneQ14;
    return raw;
  endfunction

  function automatic rgb_t predict_rgb(input logic [8:0] hue, input logic [15:0] sat,
                                       input logic [15:0] val);
    int unsigned sat_lvl, val_lvl, hue_n, chroma, second, base, rem, hue_off;
    int unsigned r, g, b;
    sector_e     sec;
    rgb_t        px;
    sat_lvl = clip_level(sat);
    val_lvl = clip_level(val);
    hue_n   = (hue >= HueWrap) ? 0 : hue;
    chroma  = (val_lvl * sat_lvl) >> FracW;
    rem     = hue_n % Hue120;
    hue_off = (rem >= Hue60) ? rem - Hue60 : Hue60 - rem;
    second  = chroma * (Hue60 - hue_off) / Hue60;
    base    = val_lvl - chroma;
    sec     = sector_e'(hue_n / Hue60);
    case (sec)
      SEC_RED_YEL: begin r = chroma; g = second; b = 0;      end
      SEC_YEL_GRN: begin r = second; g = chroma; b = 0;      end
      SEC_GRN_CYN: begin r = 0;      g = chroma; b = second; end
      SEC_CYN_BLU: begin r = 0;      g = second; b = chroma; end
      SEC_BLU_MAG: begin r = second; g = 0;      b = chroma; end
      default: begin     r = chroma; g = 0;      b = second; end
    endcase
    px.red   = 8'((r + base) * ChanFull / OneQ14);
    px.green = 8'((g + base) * ChanFull / OneQ14);
    px.blue  = 8'((b + base) * ChanFull / OneQ14);
    return px;
  endfunction

  function automatic logic [15:0] random_q14();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      6: return $urandom_range(0, 1) ? 16'(OneQ14) : 16'd0;
      7: return 16'($urandom_range(16385, 32767));
      8: return 16'($urandom_range(32768, 65535));
      9: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 16384));
    endcase
  endfunction

  task automatic add_pixel(input logic [8:0] hue, input logic [15:0] sat,
                           input logic [15:0] val, input int unsigned gap, input bit drain);
    pixel_req_t req;
    req.hue   = hue;
    req.sat   = sat;
    req.val   = val;
    req.gap   = gap;
    req.drain = drain;
    pending_q.push_back(req);
  endtask

  task automatic flag_channel(input string chan, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH word %0d %s: expected %0d, got %0d", words_out, chan, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (in_fire) begin
        expected_rgb_q.push_back(predict_rgb(hue_deg_i, saturation_i, brightness_i));
        words_in <= words_in + 1;
      end
      if (in_valid_i && !in_fire) begin
        // hold the stalled word
      end else if (in_fire && cur_gap != 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= cur_gap - 1;
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].drain && expected_rgb_q.size() != 0)) begin
        hue_deg_i    <= pending_q[0].hue;
        saturation_i <= pending_q[0].sat;
        brightness_i <= pending_q[0].val;
        cur_gap      <= pending_q[0].gap;
        in_valid_i   <= 1'b1;
        pending_q.delete(0);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_fire) begin
      rgb_t        want;
      int unsigned n;
      if (expected_rgb_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH unexpected word: got %0d %0d %0d", red_o, green_o, blue_o);
      end else begin
        want = expected_rgb_q.pop_front();
        flag_channel("red", want.red, red_o);
        flag_channel("green", want.green, green_o);
        flag_channel("blue", want.blue, blue_o);
      end
      words_out <= words_out + 1;
      n = (words_out % 200 < 40) ? 0 : $urandom_range(0, 5);
      stall_left  <= n;
      out_stall_i <= (n != 0);
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end
  end

  always @(posedge clk_i) begin
    if (in_fire || out_fire) begin
      idle_count <= 0;
    end else if (idle_count >= IdleLimit) begin
      $display("Watchdog expired after %0d idle cycles", idle_count);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    int unsigned hue_r, gap;
    bit          calm;
    add_pixel(9'd0,   16'd16384, 16'd16384, 0, 0);
    add_pixel(9'd60,  16'd16384, 16'd16384, 1, 0);
    add_pixel(9'd120, 16'd16384, 16'd16384, 0, 0);
    add_pixel(9'd180, 16'd16384, 16'd16384, 2, 0);
    add_pixel(9'd240, 16'd16384, 16'd16384, 0, 0);
    add_pixel(9'd300, 16'd16384, 16'd16384, 0, 0);
    add_pixel(9'd359, 16'd16384, 16'd16384, 3, 0);
    add_pixel(9'd360, 16'd16384, 16'd16384, 0, 0);
    add_pixel(9'd361, 16'd12000, 16'd16384, 0, 0);
    add_pixel(9'd511, 16'd16384, 16'd9000,  1, 0);
    add_pixel(9'd30,  16'h8000,  16'd16384, 0, 0);
    add_pixel(9'd30,  16'hFFFF,  16'd16384, 0, 0);
    add_pixel(9'd30,  16'd16385, 16'd16384, 4, 0);
    add_pixel(9'd30,  16'h7FFF,  16'd10000, 0, 0);
    add_pixel(9'd90,  16'd16384, 16'h8000,  0, 0);
    add_pixel(9'd90,  16'd16384, 16'hFFFF,  5, 0);
    add_pixel(9'd90,  16'd9000,  16'd16385, 0, 0);
    add_pixel(9'd90,  16'd9000,  16'h7FFF,  0, 0);
    add_pixel(9'd200, 16'd16384, 16'd0,     0, 0);
    add_pixel(9'd150, 16'd0,     16'd12345, 2, 0);
    add_pixel(9'd330, 16'd16384, 16'd1,     0, 0);
    add_pixel(9'd45,  16'd1,     16'd16383, 0, 0);
    add_pixel(9'd270, 16'd8192,  16'd8192,  0, 0);
    directed_n = pending_q.size();
    for (int i = 0; i < RandomN; i++) begin
      calm  = (i % 300) < 60;
      gap   = calm ? 0 : $urandom_range(0, 5);
      hue_r = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 359) : $urandom_range(0, 511);
      add_pixel(9'(hue_r), random_q14(), random_q14(), gap, (i % 400) == 0);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_rgb_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("Covered %0d pixels: %0d directed corners (sector edges, hue wrap, clamps)",
             words_in, directed_n);
    $display("and %0d random words under random gaps and stalls; %0d results checked",
             words_in - directed_n, words_out);
    if (mismatches == 0 && expected_rgb_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/hsv2rgb_pkg.sv
sv/hsv_to_rgb_converter.sv
dv/testbench.sv
